// ===== sv/base64_stream_encoder_top_macros.svh =====
// Assertion helpers used by the encoder's command queue.
`ifndef BASE64_STREAM_ENCODER_TOP_MACROS_SVH
`define BASE64_STREAM_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define B64E_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("b64e assertion failed");

// Next-cycle implication, disabled while reset is held.
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("b64e assertion failed");

`endif

// ===== sv/b64e_pkg.sv =====
`default_nettype none

package b64e_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_DIGIT = 8'h30;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } t_out_item;

    // One output character slot: a six-bit alphabet index or padding
    typedef struct packed {
        logic       is_pad;
        logic [5:0] idx;
    } t_sym;

    // Work for the back end: up to four characters from one input byte
    typedef struct packed {
        logic [1:0]      cnt_m1;
        logic            eom;
        t_sym [3:0]      syms;
    } t_cmd;

    // Position of a byte within its three-byte group
    typedef enum logic [2:0] {
        PH_0 = 3'b001,
        PH_1 = 3'b010,
        PH_2 = 3'b100
    } t_phase;

    // Map a six-bit value onto the standard base64 alphabet
    function automatic logic [7:0] sym_char(input logic [5:0] idx);
        logic [7:0] v;
        logic [7:0] c;
        v = {2'b00, idx};
        case (idx) inside
            [6'd0:6'd25]:  c = CHAR_UPPER + v;
            [6'd26:6'd51]: c = CHAR_LOWER + v - 8'd26;
            [6'd52:6'd61]: c = CHAR_DIGIT + v - 8'd52;
            6'd62:         c = CHAR_PLUS;
            default:       c = CHAR_SLASH;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/b64e_front.sv =====
`default_nettype none

module b64e_front (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_valid,
    input  b64e_pkg::t_in_item       i_item,
    input  wire                logic i_q_full,
    output logic                     o_stall,
    output logic                     o_push,
    output b64e_pkg::t_cmd           o_cmd
);

    b64e_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_left,  n_left;
    logic             accept;
    logic [7:0]       b;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept;
    assign b       = i_item.data_byte;

    // Classify the byte into the characters it completes
    always_comb begin
        o_cmd     = '0;
        o_cmd.eom = i_item.end_of_message;
        n_phase   = b64e_pkg::PH_0;
        n_left    = 4'd0;
        case (r_phase)
            b64e_pkg::PH_1: begin
                o_cmd.syms[0].idx = {r_left[1:0], b[7:4]};
                if (i_item.end_of_message) begin
                    o_cmd.cnt_m1         = 2'd2;
                    o_cmd.syms[1].idx    = {b[3:0], 2'b00};
                    o_cmd.syms[2].is_pad = 1'b1;
                end else begin
                    o_cmd.cnt_m1 = 2'd0;
                    n_left       = b[3:0];
                    n_phase      = b64e_pkg::PH_2;
                end
            end
            b64e_pkg::PH_2: begin
                o_cmd.cnt_m1      = 2'd1;
                o_cmd.syms[0].idx = {r_left, b[7:6]};
                o_cmd.syms[1].idx = b[5:0];
            end
            default: begin
                o_cmd.syms[0].idx = b[7:2];
                if (i_item.end_of_message) begin
                    o_cmd.cnt_m1         = 2'd3;
                    o_cmd.syms[1].idx    = {b[1:0], 4'b0000};
                    o_cmd.syms[2].is_pad = 1'b1;
                    o_cmd.syms[3].is_pad = 1'b1;
                end else begin
                    o_cmd.cnt_m1 = 2'd0;
                    n_left       = {2'b00, b[1:0]};
                    n_phase      = b64e_pkg::PH_1;
                end
            end
        endcase
    end

    // Advance group position on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64e_pkg::PH_0;
            r_left  <= 4'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

`default_nettype wire

// ===== sv/b64e_queue.sv =====
`default_nettype none

`include "base64_stream_encoder_top_macros.svh"

module b64e_queue #(
    parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  wire            logic i_clk,
    input  wire            logic i_rst_n,
    input  wire            logic i_push,
    input  b64e_pkg::t_cmd       i_cmd,
    output logic                 o_full,
    input  wire            logic i_pop,
    output logic                 o_valid,
    output b64e_pkg::t_cmd       o_head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64e_pkg::t_cmd  r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Wrap pointers and track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `B64E_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `B64E_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid)
    `B64E_ASSERT_NEXT(a_count_tracks, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

`default_nettype wire

// ===== sv/b64e_back.sv =====
`default_nettype none

module b64e_back (
    input  wire             logic i_clk,
    input  wire             logic i_rst_n,
    input  wire             logic i_q_valid,
    input  b64e_pkg::t_cmd        i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire             logic i_stall,
    output b64e_pkg::t_out_item   o_item
);

    logic [1:0]     r_idx, n_idx;
    logic           r_valid;
    logic [7:0]     r_char;
    logic           r_last;
    logic           load;
    logic           at_end;
    b64e_pkg::t_sym cur;

    assign load   = i_q_valid && (!r_valid || !i_stall);
    assign at_end = (r_idx == i_head.cnt_m1);
    assign o_pop  = load && at_end;
    assign cur    = i_head.syms[r_idx];
    assign n_idx  = at_end ? 2'd0 : r_idx + 2'd1;

    assign o_valid         = r_valid;
    assign o_item.out_char = r_char;
    assign o_item.out_last = r_last;

    // Step through the head command's characters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_idx   <= n_idx;
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the output character until taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= cur.is_pad ? b64e_pkg::PAD_CHAR : b64e_pkg::sym_char(cur.idx);
            r_last <= i_head.eom && at_end;
        end
    end

endmodule

`default_nettype wire

// ===== sv/base64_stream_encoder_top.sv =====
//  channel | valid   | stall   | payload  | item
//  --------+---------+---------+----------+--------------------------------
//  input   | i_valid | o_stall | i_item   | one message byte + end flag
//  output  | o_valid | i_stall | o_item   | one base64 character + last flag
//
//  The front accepts one byte per cycle while the command queue has room.
//  The back emits one character per cycle from its output register while i_stall
//  is low; a byte yields 1 to 4 characters (2 for the third byte of a group,
//  4 at most when the message ends at group start).
//  An accepted byte passes through the command queue and then the output register.
//  Synchronous active-low reset clears group position, queue and output valid.
//  Output stall holds the character; input stall rises only when the queue fills.
`default_nettype none

module base64_stream_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  wire                 logic i_clk,
    input  wire                 logic i_rst_n,
    input  wire                 logic i_valid,
    output logic                      o_stall,
    input  b64e_pkg::t_in_item        i_item,
    output logic                      o_valid,
    input  wire                 logic i_stall,
    output b64e_pkg::t_out_item       o_item
);

    logic           push;
    logic           q_full;
    logic           q_valid;
    logic           pop;
    b64e_pkg::t_cmd cmd;
    b64e_pkg::t_cmd head;

    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_q_full(q_full),
        .o_stall (o_stall),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    b64e_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head)
    );

    b64e_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_item   (o_item)
    );

endmodule

`default_nettype wire

// ===== tb/sv/base64_stream_encoder_top_test.sv =====
module base64_stream_encoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import b64e_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_SHOWN      = 10;
    localparam int ITEMS_PER_LEG  = 51;

    // Position of the next byte within its three-byte group
    typedef enum logic [1:0] {
        GRP_FIRST  = 2'd0,
        GRP_SECOND = 2'd1,
        GRP_THIRD  = 2'd2
    } t_grp_pos;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_item;

    // Encoder state mirror and expected characters
    t_grp_pos  grp_pos    = GRP_FIRST;
    logic [3:0] carry_bits = '0;
    t_out_item exp_chars[$];
    t_in_item  pend_bytes[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_count = 0;
    int errors = 0;
    int bytes_in = 0;
    int chars_out = 0;
    int msgs = 0;
    int full_seen = 0;

    base64_stream_encoder_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Map a six-bit index onto the standard alphabet
    function automatic logic [7:0] b64_symbol(input logic [5:0] idx);
        logic [7:0] v;
        v = {2'b00, idx};
        if (idx < 6'd26) begin
            return 8'h41 + v;
        end else if (idx < 6'd52) begin
            return 8'h61 + (v - 8'd26);
        end else if (idx < 6'd62) begin
            return 8'h30 + (v - 8'd52);
        end else if (idx == 6'd62) begin
            return 8'h2B;
        end
        return 8'h2F;
    endfunction

    function automatic void push_char(input logic [7:0] c, input logic last);
        t_out_item r;
        r.out_char = c;
        r.out_last = last;
        exp_chars.push_back(r);
    endfunction

    // Advance the group state by one byte and queue the characters it completes
    function automatic void encode_byte(input t_in_item it);
        logic [7:0] b;
        logic       eom;
        b   = it.data_byte;
        eom = it.end_of_message;
        case (grp_pos)
            GRP_SECOND: begin
                push_char(b64_symbol({carry_bits[1:0], b[7:4]}), 1'b0);
                if (eom) begin
                    push_char(b64_symbol({b[3:0], 2'b00}), 1'b0);
                    push_char(PAD_CHAR, 1'b1);
                    grp_pos    = GRP_FIRST;
                    carry_bits = '0;
                end else begin
                    carry_bits = b[3:0];
                    grp_pos    = GRP_THIRD;
                end
            end
            GRP_THIRD: begin
                push_char(b64_symbol({carry_bits, b[7:6]}), 1'b0);
                push_char(b64_symbol(b[5:0]), eom);
                grp_pos    = GRP_FIRST;
                carry_bits = '0;
            end
            default: begin
                push_char(b64_symbol(b[7:2]), 1'b0);
                if (eom) begin
                    push_char(b64_symbol({b[1:0], 4'b0000}), 1'b0);
                    push_char(PAD_CHAR, 1'b0);
                    push_char(PAD_CHAR, 1'b1);
                    grp_pos    = GRP_FIRST;
                    carry_bits = '0;
                end else begin
                    carry_bits = {2'b00, b[1:0]};
                    grp_pos    = GRP_SECOND;
                end
            end
        endcase
    endfunction

    // Queue one message; the final byte carries the end flag
    task automatic add_message(input logic [7:0] bytes[$]);
        t_in_item it;
        for (int k = 0; k < bytes.size(); k++) begin
            it.data_byte      = bytes[k];
            it.end_of_message = (k == bytes.size() - 1);
            pend_bytes.push_back(it);
        end
        msgs++;
    endtask

    task automatic add_random_message(output int len);
        logic [7:0] bytes[$];
        if ($urandom_range(9) < 8) begin
            len = $urandom_range(1, 7);
        end else begin
            len = $urandom_range(8, 30);
        end
        for (int k = 0; k < len; k++) begin
            bytes.push_back(8'($urandom));
        end
        add_message(bytes);
    endtask

    task automatic report_bad(input string what, input t_out_item want,
                              input t_out_item got);
        errors++;
        if (errors <= MAX_SHOWN) begin
            $display("%0t: %s: expected char %h last %b, got char %h last %b",
                     $realtime, what, want.out_char, want.out_last,
                     got.out_char, got.out_last);
        end
    endtask

    // Drive bytes: hold while stalled, otherwise offer the next one or idle
    always @(posedge i_clk) begin : drive_p
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                encode_byte(i_item);
                bytes_in++;
            end
            if (i_valid && o_stall) begin
                full_seen++;
            end else if (pend_bytes.size() != 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                i_item  <= pend_bytes.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Check characters in order and drive the output stall
    always @(posedge i_clk) begin : watch_p
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            chars_out++;
            if (exp_chars.size() == 0) begin
                want = '0;
                report_bad("character with nothing expected", want, o_item);
            end else begin
                want = exp_chars.pop_front();
                if (o_item.out_char !== want.out_char ||
                    o_item.out_last !== want.out_last) begin
                    report_bad("character mismatch", want, o_item);
                end
            end
        end
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // End the run when neither side moves an item for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_count <= 0;
        end else if (idle_count >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", idle_count);
            $display("FAILURE");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        int added;
        int len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, short groups, all padding cases, '+' and '/'
        add_message('{8'h00});
        add_message('{8'hFF});
        add_message('{8'hFF, 8'h00});
        add_message('{8'h00, 8'hFF});
        add_message('{8'hFF, 8'hFF, 8'hFF});
        add_message('{8'h00, 8'h00, 8'h00});
        add_message('{8'hFB, 8'hEF, 8'hBE});
        add_message('{8'h01, 8'h80, 8'h7F, 8'hFE});
        add_message('{8'h55, 8'hAA});
        while (pend_bytes.size() != 0) @(negedge i_clk);

        // Random legs: none, sender gaps, receiver stalls, both, long hold-off
        for (int leg = 0; leg < 5; leg++) begin
            case (leg)
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                3: begin send_idle_pct = 11; recv_stall_pct = 11; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (leg == 4) begin
                hold_req++;
            end
            added = 0;
            while (added < ITEMS_PER_LEG) begin
                add_random_message(len);
                added += len;
            end
            while (pend_bytes.size() != 0) @(negedge i_clk);
        end

        // Drain the last characters
        while (i_valid || exp_chars.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (exp_chars.size() != 0) begin
            errors++;
            $display("%0d expected characters never arrived", exp_chars.size());
        end

        $display("covered %0d messages, %0d bytes in, %0d characters out",
                 msgs, bytes_in, chars_out);
        $display("input held by a full block on %0d cycles, %0d failures",
                 full_seen, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
